// File: sv/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ERS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define ERS_ASSERT_NORST(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define ERS_ASSERT(lbl, clk, rst, prop)
`define ERS_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

// File: sv/ers_pkg.sv
package ers_pkg;

   localparam logic [30:0] SIN_A1 = 31'd1686629713;
   localparam logic [30:0] SIN_A3 = 31'd693598665;
   localparam logic [30:0] SIN_A5 = 31'd85569306;
   localparam logic [30:0] SIN_A7 = 31'd5026995;
   localparam logic [30:0] SIN_A9 = 31'd172271;

   localparam logic [16:0] QUARTER_TURN = 17'h08000;

   localparam logic [2:0] SIN_STEP_SQ  = 3'd0;
   localparam logic [2:0] SIN_STEP_OUT = 3'd5;

   localparam logic [2:0] FUNC_STEP      = 3'd0;
   localparam logic [2:0] FUNC_LOAD_NORM = 3'd1;
   localparam logic [2:0] FUNC_LOAD_COEF = 3'd2;
   localparam logic [2:0] FUNC_SET_POSE  = 3'd3;
   localparam logic [2:0] FUNC_READ_COEF = 3'd4;

   localparam logic [1:0] CSR_STEP_TIME   = 2'd0;
   localparam logic [1:0] CSR_TURN_GAIN   = 2'd1;
   localparam logic [1:0] CSR_EDGE_MARGIN = 2'd2;

   typedef struct packed {
      logic        start;
      logic [16:0] phase;
   } sin_req_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic signed [16:0] value;
   } sin_rsp_type;

   // Horner constant from which the product is subtracted at each polynomial step
   function automatic logic [30:0] sin_coef(input logic [2:0] step);
      logic [30:0] c;
      case (step)
         3'd1:    c = SIN_A7;
         3'd2:    c = SIN_A5;
         3'd3:    c = SIN_A3;
         3'd4:    c = SIN_A1;
         default: c = SIN_A9;
      endcase
      return c;
   endfunction

endpackage

// File: sv/ers_sine.sv
module ers_sine (
   input  logic                 clock,
   input  logic                 reset,
   input  ers_pkg::sin_req_type sin_req,
   output ers_pkg::sin_rsp_type sin_rsp
);

   logic               busy_ff, done_ff, neg_ff;
   logic [2:0]         step_ff;
   logic [30:0]        z_ff, z2_ff, p_ff;
   logic signed [16:0] val_ff;

   logic [15:0] f_in;
   logic [30:0] mul_a, mul_b, sh;
   logic [61:0] prod;
   logic [31:0] rsum;
   logic [16:0] rr;

   always_comb begin
      f_in = {1'b0, sin_req.phase[14:0]};
      if (sin_req.phase[15]) begin
         f_in = 16'h8000 - f_in;
      end
      mul_a = (step_ff == ers_pkg::SIN_STEP_SQ) ? z_ff : p_ff;
      mul_b = (step_ff == ers_pkg::SIN_STEP_SQ || step_ff == ers_pkg::SIN_STEP_OUT) ? z_ff : z2_ff;
      prod  = 62'(mul_a) * 62'(mul_b);
      sh    = prod[60:30];
      rsum  = {1'b0, sh} + 32'd16384;
      rr    = rsum[31:15];
      if (rr > 17'd32768) begin
         rr = 17'd32768;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= ers_pkg::SIN_STEP_SQ;
      end else begin
         done_ff <= 1'b0;
         if (!busy_ff) begin
            if (sin_req.start) begin
               busy_ff <= 1'b1;
               step_ff <= ers_pkg::SIN_STEP_SQ;
               z_ff    <= {f_in, 15'b0};
               neg_ff  <= sin_req.phase[16];
               p_ff    <= ers_pkg::SIN_A9;
            end
         end else begin
            step_ff <= step_ff + 3'd1;
            if (step_ff == ers_pkg::SIN_STEP_SQ) begin
               z2_ff <= sh;
            end else if (step_ff == ers_pkg::SIN_STEP_OUT) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
               val_ff  <= neg_ff ? -$signed(rr) : $signed(rr);
            end else begin
               p_ff <= ers_pkg::sin_coef(step_ff) - sh;
            end
         end
      end
   end

   assign sin_rsp.busy  = busy_ff;
   assign sin_rsp.done  = done_ff;
   assign sin_rsp.value = val_ff;

endmodule

// File: sv/ergodic_rollout_step.sv
// Loads, pose set and unused codes pass from EXEC to DONE; a coefficient read adds RDWAIT.
// Step: 2*(K+1) sine evaluations (shared 6-step polynomial unit), the pose states MV1 to
// MV4, bit-serial weight division and coefficient read-modify-write of all K*K entries, both
// skipped when the new time is zero, then the time update. One request in flight.
// Synchronous reset restores register defaults, zero pose and time, and clears coefficient
// valid bits; the normalizer memory is undefined until written.
`include "assert_macros.svh"

module ergodic_rollout_step #(
   parameter int COEFS_PER_AXIS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_func,
   input  logic [5:0]         req_entry_index,
   input  logic signed [31:0] req_load_value,
   input  logic [15:0]        req_new_x,
   input  logic [15:0]        req_new_y,
   input  logic [15:0]        req_new_heading,
   input  logic [31:0]        req_new_time,
   input  logic signed [15:0] req_drive_left,
   input  logic signed [15:0] req_drive_right,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_pose_x,
   output logic [15:0]        rsp_pose_y,
   output logic [15:0]        rsp_pose_heading,
   output logic [31:0]        rsp_time_now,
   output logic signed [31:0] rsp_read_value,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   localparam int TS = COEFS_PER_AXIS * COEFS_PER_AXIS;
   localparam int AW = $clog2(TS);
   localparam int KW = $clog2(COEFS_PER_AXIS);
   localparam logic [4:0] DIV_TOP = 5'd30;

   typedef enum logic [16:0] {
      ST_IDLE   = 17'b00000000000000001,
      ST_EXEC   = 17'b00000000000000010,
      ST_RDWAIT = 17'b00000000000000100,
      ST_HTRIG  = 17'b00000000000001000,
      ST_MV1    = 17'b00000000000010000,
      ST_MV2    = 17'b00000000000100000,
      ST_MV3    = 17'b00000000001000000,
      ST_MV4    = 17'b00000000010000000,
      ST_BTRIG  = 17'b00000000100000000,
      ST_DIV    = 17'b00000001000000000,
      ST_B_RD   = 17'b00000010000000000,
      ST_B_M1   = 17'b00000100000000000,
      ST_B_M2   = 17'b00001000000000000,
      ST_B_M3   = 17'b00010000000000000,
      ST_B_WR   = 17'b00100000000000000,
      ST_TIME   = 17'b01000000000000000,
      ST_DONE   = 17'b10000000000000000
   } state_type;

   state_type state_ff;

   logic [2:0]         func_ff;
   logic [5:0]         idx_ff;
   logic signed [31:0] lv_ff;
   logic [15:0]        nx_ff, ny_ff, nh_ff;
   logic [31:0]        nt_ff;
   logic signed [15:0] dl_ff, dr_ff;

   logic [15:0] dt_ff, tg_ff;
   logic [14:0] em_ff;
   logic [15:0] x_ff, y_ff, h_ff;
   logic [31:0] t_ff;

   logic               rsp_valid_ff;
   logic [15:0]        rsp_x_ff, rsp_y_ff, rsp_h_ff;
   logic [31:0]        rsp_t_ff;
   logic signed [31:0] rv_ff, rsp_rv_ff;

   logic signed [16:0] ch_ff, sh_ff;
   logic               ax_ff, started_ff;
   logic [KW-1:0]      k_ff, ki_ff, kj_ff;
   logic signed [16:0] cx_ff [COEFS_PER_AXIS];
   logic signed [16:0] cy_ff [COEFS_PER_AXIS];
   logic signed [33:0] base_ff, dd_ff;
   logic signed [50:0] mv_ff;

   logic [33:0] rem_ff;
   logic [32:0] den_ff;
   logic [30:0] w_ff;
   logic [4:0]  dcnt_ff;

   logic [AW-1:0]      bidx_ff;
   logic signed [31:0] cc_ff, c_ff;
   logic signed [63:0] nf_ff;
   logic signed [34:0] df_ff;
   logic signed [66:0] md_ff;

   logic [31:0] norm_mem [TS];
   logic [31:0] coef_mem [TS];
   logic [TS-1:0] coef_vld_ff;
   logic [31:0] norm_rd_ff, coef_rd_ff;
   logic        rd_vld_ff;

   ers_pkg::sin_req_type sin_req;
   ers_pkg::sin_rsp_type sin_rsp;

   logic               in_range;
   logic [AW-1:0]      req_addr, coef_ra, coef_wa;
   logic               coef_re, coef_we;
   logic [31:0]        coef_wd;
   logic [16:0]        sum_lr, dif_rl;
   logic signed [33:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [50:0] mv_prod;
   logic [20:0]        kp;
   logic [32:0]        den_new;
   logic [33:0]        trial;
   logic               ge;
   logic signed [37:0] nc;
   logic [31:0]        nc_sat;
   logic [32:0]        t_sum;
   logic               rsp_load;
   logic               sine_owner;

   function automatic logic [15:0] clamp_pos(input logic signed [24:0] v,
                                             input logic [14:0] m);
      logic signed [24:0] lo, hi;
      lo = $signed({10'b0, m});
      hi = (m == 15'd0) ? 25'sd65535 : 25'sd65536 - lo;
      if (v < lo) begin
         return lo[15:0];
      end else if (v > hi) begin
         return hi[15:0];
      end
      return v[15:0];
   endfunction

   always_comb begin
      in_range = ({26'b0, idx_ff} < 32'(TS));
      req_addr = AW'(idx_ff);
      sum_lr   = 17'($signed({dl_ff[15], dl_ff}) + $signed({dr_ff[15], dr_ff}));
      dif_rl   = 17'($signed({dr_ff[15], dr_ff}) - $signed({dl_ff[15], dl_ff}));

      mul_a = (state_ff == ST_MV3) ? dd_ff : base_ff;
      case (state_ff)
         ST_MV1:  mul_b = ch_ff;
         ST_MV2:  mul_b = sh_ff;
         default: mul_b = $signed({1'b0, tg_ff});
      endcase
      mv_prod = 51'(mul_a) * 51'(mul_b);

      kp = 21'(k_ff) * 21'(ax_ff ? y_ff : x_ff);
      sine_owner    = (state_ff == ST_HTRIG) || (state_ff == ST_BTRIG);
      sin_req.start = sine_owner && !started_ff && !sin_rsp.busy;
      if (state_ff == ST_HTRIG) begin
         sin_req.phase = {h_ff, 1'b0} + (ax_ff ? 17'd0 : ers_pkg::QUARTER_TURN);
      end else begin
         sin_req.phase = kp[16:0] + ers_pkg::QUARTER_TURN;
      end

      den_new = {1'b0, t_ff} + {17'b0, dt_ff};
      trial   = {rem_ff[32:0], (dcnt_ff == DIV_TOP) ? dt_ff[0] : 1'b0};
      ge      = (trial >= {1'b0, den_ff});

      nc = 38'(c_ff) + 38'($signed(md_ff[66:30]));
      if (nc > 38'sd2147483647) begin
         nc_sat = 32'h7FFFFFFF;
      end else if (nc < -38'sd2147483648) begin
         nc_sat = 32'h80000000;
      end else begin
         nc_sat = nc[31:0];
      end
      t_sum = {1'b0, t_ff} + {17'b0, dt_ff};

      rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

      coef_we = 1'b0;
      coef_wa = req_addr;
      coef_wd = lv_ff;
      if (state_ff == ST_EXEC && func_ff == ers_pkg::FUNC_LOAD_COEF && in_range) begin
         coef_we = 1'b1;
      end else if (state_ff == ST_B_WR) begin
         coef_we = 1'b1;
         coef_wa = bidx_ff;
         coef_wd = nc_sat;
      end
      coef_re = (state_ff == ST_B_RD) || (state_ff == ST_EXEC);
      coef_ra = (state_ff == ST_B_RD) ? bidx_ff : req_addr;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_EXEC && func_ff == ers_pkg::FUNC_LOAD_NORM && in_range) begin
         norm_mem[req_addr] <= lv_ff;
      end
      if (state_ff == ST_B_RD) begin
         norm_rd_ff <= norm_mem[bidx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_wa] <= coef_wd;
      end
      if (coef_re) begin
         coef_rd_ff <= coef_mem[coef_ra];
         rd_vld_ff  <= coef_vld_ff[coef_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_vld_ff <= '0;
      end else if (coef_we) begin
         coef_vld_ff[coef_wa] <= 1'b1;
      end
   end

   ers_sine u_sine (
      .clock   (clock),
      .reset   (reset),
      .sin_req (sin_req),
      .sin_rsp (sin_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         started_ff   <= 1'b0;
         dt_ff        <= 16'd655;
         tg_ff        <= 16'd256;
         em_ff        <= 15'd7;
         x_ff         <= '0;
         y_ff         <= '0;
         h_ff         <= '0;
         t_ff         <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               ers_pkg::CSR_STEP_TIME:   dt_ff <= csr_wdata;
               ers_pkg::CSR_TURN_GAIN:   tg_ff <= csr_wdata;
               ers_pkg::CSR_EDGE_MARGIN: em_ff <= csr_wdata[14:0];
               default: ;
            endcase
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (sin_req.start) begin
            started_ff <= 1'b1;
         end else if (sin_rsp.done) begin
            started_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  func_ff  <= req_func;
                  idx_ff   <= req_entry_index;
                  lv_ff    <= req_load_value;
                  nx_ff    <= req_new_x;
                  ny_ff    <= req_new_y;
                  nh_ff    <= req_new_heading;
                  nt_ff    <= req_new_time;
                  dl_ff    <= req_drive_left;
                  dr_ff    <= req_drive_right;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               rv_ff <= '0;
               case (func_ff)
                  ers_pkg::FUNC_STEP: begin
                     base_ff  <= $signed(sum_lr) * $signed({1'b0, dt_ff});
                     dd_ff    <= $signed(dif_rl) * $signed({1'b0, dt_ff});
                     ax_ff    <= 1'b0;
                     k_ff     <= '0;
                     state_ff <= ST_HTRIG;
                  end
                  ers_pkg::FUNC_SET_POSE: begin
                     x_ff     <= nx_ff;
                     y_ff     <= ny_ff;
                     h_ff     <= nh_ff;
                     t_ff     <= nt_ff;
                     state_ff <= ST_DONE;
                  end
                  ers_pkg::FUNC_READ_COEF: state_ff <= ST_RDWAIT;
                  default: state_ff <= ST_DONE;
               endcase
            end
            ST_RDWAIT: begin
               rv_ff    <= (in_range && rd_vld_ff) ? coef_rd_ff : '0;
               state_ff <= ST_DONE;
            end
            ST_HTRIG: begin
               if (sin_rsp.done) begin
                  ax_ff <= !ax_ff;
                  if (!ax_ff) begin
                     ch_ff <= sin_rsp.value;
                  end else begin
                     sh_ff    <= sin_rsp.value;
                     state_ff <= ST_MV1;
                  end
               end
            end
            ST_MV1: begin
               mv_ff    <= mv_prod;
               state_ff <= ST_MV2;
            end
            ST_MV2: begin
               x_ff     <= clamp_pos($signed({9'b0, x_ff}) +
                                     $signed({{2{mv_ff[50]}}, mv_ff[50:28]}), em_ff);
               mv_ff    <= mv_prod;
               state_ff <= ST_MV3;
            end
            ST_MV3: begin
               y_ff     <= clamp_pos($signed({9'b0, y_ff}) +
                                     $signed({{2{mv_ff[50]}}, mv_ff[50:28]}), em_ff);
               mv_ff    <= mv_prod;
               state_ff <= ST_MV4;
            end
            ST_MV4: begin
               h_ff     <= h_ff + mv_ff[35:20];
               state_ff <= ST_BTRIG;
            end
            ST_BTRIG: begin
               if (sin_rsp.done) begin
                  ax_ff <= !ax_ff;
                  if (!ax_ff) begin
                     cx_ff[k_ff] <= sin_rsp.value;
                  end else begin
                     cy_ff[k_ff] <= sin_rsp.value;
                     k_ff        <= k_ff + KW'(1);
                     if (k_ff == KW'(COEFS_PER_AXIS - 1)) begin
                        rem_ff   <= {19'b0, dt_ff[15:1]};
                        den_ff   <= den_new;
                        dcnt_ff  <= DIV_TOP;
                        w_ff     <= '0;
                        state_ff <= (den_new == '0) ? ST_TIME : ST_DIV;
                     end
                  end
               end
            end
            ST_DIV: begin
               rem_ff  <= ge ? trial - {1'b0, den_ff} : trial;
               w_ff    <= {w_ff[29:0], ge};
               dcnt_ff <= dcnt_ff - 5'd1;
               if (dcnt_ff == 5'd0) begin
                  bidx_ff  <= '0;
                  ki_ff    <= '0;
                  kj_ff    <= '0;
                  state_ff <= ST_B_RD;
               end
            end
            ST_B_RD: begin
               cc_ff    <= 32'(cx_ff[ki_ff] * cy_ff[kj_ff]);
               state_ff <= ST_B_M1;
            end
            ST_B_M1: begin
               nf_ff    <= 64'($signed(norm_rd_ff)) * 64'(cc_ff);
               c_ff     <= rd_vld_ff ? $signed(coef_rd_ff) : 32'sd0;
               state_ff <= ST_B_M2;
            end
            ST_B_M2: begin
               df_ff    <= 35'($signed(nf_ff[63:30])) - 35'(c_ff);
               state_ff <= ST_B_M3;
            end
            ST_B_M3: begin
               md_ff    <= 67'(df_ff) * $signed({36'b0, w_ff});
               state_ff <= ST_B_WR;
            end
            ST_B_WR: begin
               bidx_ff <= bidx_ff + AW'(1);
               if (ki_ff == KW'(COEFS_PER_AXIS - 1)) begin
                  ki_ff <= '0;
                  kj_ff <= kj_ff + KW'(1);
               end else begin
                  ki_ff <= ki_ff + KW'(1);
               end
               state_ff <= (bidx_ff == AW'(TS - 1)) ? ST_TIME : ST_B_RD;
            end
            ST_TIME: begin
               t_ff     <= t_sum[32] ? 32'hFFFFFFFF : t_sum[31:0];
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (rsp_load) begin
                  rsp_x_ff  <= x_ff;
                  rsp_y_ff  <= y_ff;
                  rsp_h_ff  <= h_ff;
                  rsp_t_ff  <= t_ff;
                  rsp_rv_ff <= rv_ff;
                  state_ff  <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pose_x       = rsp_x_ff;
   assign rsp_pose_y       = rsp_y_ff;
   assign rsp_pose_heading = rsp_h_ff;
   assign rsp_time_now     = rsp_t_ff;
   assign rsp_read_value   = rsp_rv_ff;

   `ERS_ASSERT(a_accept_busy, clock, reset, (req_valid && req_ready) |=> !req_ready)
   `ERS_ASSERT(a_weight_range, clock, reset, (state_ff == ST_B_RD) |-> (w_ff <= 31'h40000000))
   `ERS_ASSERT(a_sine_owner, clock, reset, sin_rsp.done |-> sine_owner)
   `ERS_ASSERT_NORST(a_rsp_reset, clock, reset |=> !rsp_valid)

endmodule

// File: tb/sv/ers_rollout_checker.sv
module ers_rollout_checker #(
   parameter int K = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [2:0]         req_func,
   input  logic [5:0]         req_entry_index,
   input  logic signed [31:0] req_load_value,
   input  logic [15:0]        req_new_x,
   input  logic [15:0]        req_new_y,
   input  logic [15:0]        req_new_heading,
   input  logic [31:0]        req_new_time,
   input  logic signed [15:0] req_drive_left,
   input  logic signed [15:0] req_drive_right,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [15:0]        rsp_pose_x,
   input  logic [15:0]        rsp_pose_y,
   input  logic [15:0]        rsp_pose_heading,
   input  logic [31:0]        rsp_time_now,
   input  logic signed [31:0] rsp_read_value,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   output int                 fail_count,
   output int                 pending,
   output int                 steps_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [15:0]        x;
      logic [15:0]        y;
      logic [15:0]        heading;
      logic [31:0]        t;
      logic signed [31:0] rd;
   } pose_rsp_type;

   localparam int ENTRIES = K * K;

   logic [15:0]        dt_q, gain_q;
   logic [14:0]        margin_q;
   logic [15:0]        px_q, py_q, hd_q;
   logic [31:0]        time_q;
   logic signed [31:0] coef_q [ENTRIES];
   logic signed [31:0] norm_q [ENTRIES];
   pose_rsp_type       expected_rsps [$];

   function automatic int sine_q15(logic [31:0] ph_in);
      logic [16:0]          ph;
      logic [1:0]           quad;
      longint unsigned      f, z, z2, p, r;
      ph = ph_in[16:0];
      quad = ph[16:15];
      f = ph[14:0];
      if (quad[0]) f = 64'h8000 - f;
      z = f << 15;
      z2 = (z * z) >> 30;
      p = ers_pkg::SIN_A9;
      p = ers_pkg::SIN_A7 - ((p * z2) >> 30);
      p = ers_pkg::SIN_A5 - ((p * z2) >> 30);
      p = ers_pkg::SIN_A3 - ((p * z2) >> 30);
      p = ers_pkg::SIN_A1 - ((p * z2) >> 30);
      r = (p * z) >> 30;
      r = (r + (1 << 14)) >> 15;
      if (r > 32768) r = 32768;
      return quad[1] ? -int'(r) : int'(r);
   endfunction

   function automatic int cosine_q15(logic [31:0] ph);
      return sine_q15(ph + 32'h8000);
   endfunction

   function automatic logic [15:0] clamp_edge(longint v);
      longint lo, hi;
      lo = margin_q;
      hi = 65536 - longint'(margin_q);
      if (hi > 65535) hi = 65535;
      if (v < lo) v = lo;
      else if (v > hi) v = hi;
      return v[15:0];
   endfunction

   task automatic advance_pose(longint ul, longint ur);
      int              ch, sh;
      longint          base, dh, f, c, nc, w;
      longint unsigned den, nt;
      int              cx [K];
      int              cy [K];
      int              idx;
      ch = cosine_q15({15'd0, hd_q, 1'b0});
      sh = sine_q15({15'd0, hd_q, 1'b0});
      base = (ul + ur) * longint'(dt_q);
      dh = ((ur - ul) * longint'(dt_q) * longint'(gain_q)) >>> 20;
      px_q = clamp_edge(longint'(px_q) + ((base * ch) >>> 28));
      py_q = clamp_edge(longint'(py_q) + ((base * sh) >>> 28));
      hd_q = 16'(longint'(hd_q) + dh);
      for (int k = 0; k < K; k++) begin
         cx[k] = cosine_q15(k * px_q);
         cy[k] = cosine_q15(k * py_q);
      end
      den = longint'(time_q) + longint'(dt_q);
      if (den != 0) begin
         w = longint'((64'(dt_q) << 30) / den);
         for (int kj = 0; kj < K; kj++) begin
            for (int ki = 0; ki < K; ki++) begin
               idx = ki + kj * K;
               c = coef_q[idx];
               f = (longint'(norm_q[idx]) * (longint'(cx[ki]) * longint'(cy[kj]))) >>> 30;
               nc = c + (((f - c) * w) >>> 30);
               if (nc > 64'sd2147483647) nc = 64'sd2147483647;
               else if (nc < -64'sd2147483648) nc = -64'sd2147483648;
               coef_q[idx] = nc[31:0];
            end
         end
      end
      nt = longint'(time_q) + longint'(dt_q);
      time_q = (nt > 64'hFFFFFFFF) ? 32'hFFFFFFFF : nt[31:0];
   endtask

   task automatic apply_request();
      pose_rsp_type e;
      e.rd = '0;
      case (req_func)
         ers_pkg::FUNC_STEP: begin
            advance_pose(req_drive_left, req_drive_right);
            steps_seen++;
         end
         ers_pkg::FUNC_LOAD_NORM:
            if (req_entry_index < ENTRIES) norm_q[req_entry_index] = req_load_value;
         ers_pkg::FUNC_LOAD_COEF:
            if (req_entry_index < ENTRIES) coef_q[req_entry_index] = req_load_value;
         ers_pkg::FUNC_SET_POSE: begin
            px_q = req_new_x;
            py_q = req_new_y;
            hd_q = req_new_heading;
            time_q = req_new_time;
         end
         ers_pkg::FUNC_READ_COEF:
            if (req_entry_index < ENTRIES) e.rd = coef_q[req_entry_index];
         default: ;
      endcase
      e.x = px_q;
      e.y = py_q;
      e.heading = hd_q;
      e.t = time_q;
      expected_rsps.push_back(e);
   endtask

   task automatic report(string name, longint exp_v, longint got_v);
      $display("%0t: mismatch on %s: expected %0h, got %0h", $time, name, exp_v, got_v);
      fail_count++;
   endtask

   always @(posedge clock) begin
      pose_rsp_type e;
      if (reset) begin
         dt_q = 16'd655;
         gain_q = 16'd256;
         margin_q = 15'd7;
         px_q = '0;
         py_q = '0;
         hd_q = '0;
         time_q = '0;
         for (int i = 0; i < ENTRIES; i++) begin
            coef_q[i] = '0;
            norm_q[i] = '0;
         end
         expected_rsps.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               ers_pkg::CSR_STEP_TIME:   dt_q = csr_wdata;
               ers_pkg::CSR_TURN_GAIN:   gain_q = csr_wdata;
               ers_pkg::CSR_EDGE_MARGIN: margin_q = csr_wdata[14:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) apply_request();
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: response with none expected", $time);
               fail_count++;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_pose_x !== e.x) report("pose_x", e.x, rsp_pose_x);
               if (rsp_pose_y !== e.y) report("pose_y", e.y, rsp_pose_y);
               if (rsp_pose_heading !== e.heading)
                  report("pose_heading", e.heading, rsp_pose_heading);
               if (rsp_time_now !== e.t) report("time_now", e.t, rsp_time_now);
               if (rsp_read_value !== e.rd) report("read_value", e.rd, rsp_read_value);
            end
         end
      end
      pending = expected_rsps.size();
   end
endmodule

// File: tb/sv/tb_ergodic_rollout_step.sv
module tb_ergodic_rollout_step;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] FUNC_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] FUNC_UNUSED_LAST  = 3'd7;
   localparam int         K = 8;
   localparam int         STALL_LIMIT = 20000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [2:0]         req_func = ers_pkg::FUNC_READ_COEF;
   logic [5:0]         req_entry_index = '0;
   logic signed [31:0] req_load_value = '0;
   logic [15:0]        req_new_x = '0;
   logic [15:0]        req_new_y = '0;
   logic [15:0]        req_new_heading = '0;
   logic [31:0]        req_new_time = '0;
   logic signed [15:0] req_drive_left = '0;
   logic signed [15:0] req_drive_right = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [15:0]        rsp_pose_x, rsp_pose_y, rsp_pose_heading;
   logic [31:0]        rsp_time_now;
   logic signed [31:0] rsp_read_value;
   logic               csr_we = 1'b0;
   logic [1:0]         csr_index = ers_pkg::CSR_STEP_TIME;
   logic [15:0]        csr_wdata = '0;

   int fail_count, pending, steps_seen;
   int send_idle = 0, recv_idle = 0;
   int sent = 0;
   bit holding = 1'b0;
   bit hold_go = 1'b0;
   int quiet_cycles = 0;

   ergodic_rollout_step #(.COEFS_PER_AXIS(K)) dut (.*);

   ers_rollout_checker #(.K(K)) u_checker (
      .clock, .reset, .req_valid, .req_ready, .req_func, .req_entry_index,
      .req_load_value, .req_new_x, .req_new_y, .req_new_heading, .req_new_time,
      .req_drive_left, .req_drive_right, .rsp_valid, .rsp_ready, .rsp_pose_x,
      .rsp_pose_y, .rsp_pose_heading, .rsp_time_now, .rsp_read_value,
      .csr_we, .csr_index, .csr_wdata, .fail_count, .pending, .steps_seen
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      if (holding) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
   end

   // long receiver hold-off so the block backs up into the request side
   initial begin
      wait (hold_go);
      @(negedge clock);
      holding = 1'b1;
      repeat (1500) @(negedge clock);
      holding = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_request(logic [2:0] func, logic [5:0] idx, logic [31:0] lv,
                               logic [15:0] x, logic [15:0] y, logic [15:0] hd,
                               logic [31:0] t, logic [15:0] dl, logic [15:0] dr);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_entry_index <= idx;
      req_load_value <= lv;
      req_new_x <= x;
      req_new_y <= y;
      req_new_heading <= hd;
      req_new_time <= t;
      req_drive_left <= dl;
      req_drive_right <= dr;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task automatic step_request(logic [15:0] dl, logic [15:0] dr);
      send_request(ers_pkg::FUNC_STEP, 6'($urandom), $urandom, 16'($urandom),
                   16'($urandom), 16'($urandom), $urandom, dl, dr);
   endtask

   task automatic simple_request(logic [2:0] func, logic [5:0] idx, logic [31:0] lv);
      send_request(func, idx, lv, 16'($urandom), 16'($urandom), 16'($urandom), $urandom,
                   16'($urandom), 16'($urandom));
   endtask

   task automatic pose_request(logic [15:0] x, logic [15:0] y, logic [15:0] hd,
                               logic [31:0] t);
      send_request(ers_pkg::FUNC_SET_POSE, 6'($urandom), $urandom, x, y, hd, t,
                   16'($urandom), 16'($urandom));
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_request();
      int          r;
      logic [31:0] t;
      r = $urandom_range(0, 99);
      if (r < 60) step_request(16'($urandom), 16'($urandom));
      else if (r < 68) simple_request(ers_pkg::FUNC_LOAD_COEF, 6'($urandom), $urandom);
      else if (r < 73) simple_request(ers_pkg::FUNC_LOAD_NORM, 6'($urandom), $urandom);
      else if (r < 80) begin
         t = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h100000);
         pose_request(16'($urandom), 16'($urandom), 16'($urandom), t);
      end else if (r < 95) simple_request(ers_pkg::FUNC_READ_COEF, 6'($urandom), $urandom);
      else simple_request(3'($urandom_range(FUNC_UNUSED_FIRST, FUNC_UNUSED_LAST)),
                          6'($urandom), $urandom);
   endtask

   initial begin
      logic [15:0] dts [4];
      logic [15:0] gains [4];
      logic [15:0] margins [4];
      dts = '{16'd655, 16'd65535, 16'd1, 16'($urandom_range(1, 65535))};
      gains = '{16'd256, 16'd65535, 16'd1, 16'($urandom_range(1, 65535))};
      margins = '{16'd7, 16'd32767, 16'd0, 16'($urandom_range(0, 32767))};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle = 26;
      recv_idle = 53;
      // every normalizer entry is loaded before the first step reads the table
      for (int i = 0; i < K * K; i++) begin
         if (i == 0) simple_request(ers_pkg::FUNC_LOAD_NORM, 6'(i), 32'h7FFFFFFF);
         else if (i == 1) simple_request(ers_pkg::FUNC_LOAD_NORM, 6'(i), 32'h80000000);
         else simple_request(ers_pkg::FUNC_LOAD_NORM, 6'(i), $urandom);
      end

      simple_request(ers_pkg::FUNC_READ_COEF, 6'd0, 32'd0);
      simple_request(ers_pkg::FUNC_LOAD_COEF, 6'd0, 32'h7FFFFFFF);
      simple_request(ers_pkg::FUNC_LOAD_COEF, 6'd63, 32'h80000000);
      simple_request(ers_pkg::FUNC_READ_COEF, 6'd0, 32'd0);
      simple_request(ers_pkg::FUNC_READ_COEF, 6'd63, 32'd0);
      step_request(16'h7FFF, 16'h7FFF);
      step_request(16'h8000, 16'h8000);
      step_request(16'h8000, 16'h7FFF);
      step_request(16'h7FFF, 16'h8000);
      step_request(16'h0000, 16'h0000);
      pose_request(16'h0000, 16'hFFFF, 16'hFFFF, 32'hFFFFFFF0);
      step_request(16'h7FFF, 16'h7FFF);
      step_request(16'h1000, 16'hF000);
      pose_request(16'hFFFF, 16'h0000, 16'h4000, 32'h0);
      step_request(16'h8000, 16'h8000);
      simple_request(FUNC_UNUSED_FIRST, 6'd3, 32'd0);
      simple_request(FUNC_UNUSED_LAST, 6'd3, 32'd0);
      simple_request(ers_pkg::FUNC_READ_COEF, 6'd63, 32'd0);
      pose_request(16'h8000, 16'h8000, 16'h0000, 32'h10000);
      simple_request(ers_pkg::FUNC_READ_COEF, 6'd0, 32'd0);

      for (int ph = 0; ph < 4; ph++) begin
         drain();
         write_csr(ers_pkg::CSR_STEP_TIME, dts[ph]);
         write_csr(ers_pkg::CSR_TURN_GAIN, gains[ph]);
         write_csr(ers_pkg::CSR_EDGE_MARGIN, margins[ph]);
         case (ph)
            0: begin send_idle = 26; recv_idle = 53; end
            1: begin send_idle = 53; recv_idle = 26; end
            default: begin send_idle = 0; recv_idle = 0; end
         endcase
         if (ph == 3) hold_go = 1'b1;
         for (int n = 0; n < 140; n++) random_request();
      end

      drain();
      repeat (20) @(posedge clock);
      $display("Covered %0d requests, %0d steps, four register settings incl. extremes.",
               sent, steps_seen);
      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule

// File: sim.f
+incdir+sv
sv/ers_pkg.sv
sv/ers_sine.sv
sv/ergodic_rollout_step.sv
tb/sv/ers_rollout_checker.sv
tb/sv/tb_ergodic_rollout_step.sv
